@@ rtl/dslr_pkg.sv @@
`timescale 1ns / 1ps
package dslr_pkg;

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;

   // signed position: sign bit, integer part, fraction
   localparam int ACC_W   = COORD_BITS + FRAC_BITS + 1;
   // signed increment: magnitude never exceeds one whole unit
   localparam int INC_W   = FRAC_BITS + 2;
   localparam int DVD_W   = COORD_BITS + FRAC_BITS;
   localparam int QUO_W   = FRAC_BITS + 1;
   localparam int CNT_W   = $clog2(DVD_W + 1);
   localparam int STYLE_W = 2;
   localparam int PHASE_W = 3;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [STYLE_W-1:0] STYLE_DOTTED  = 2'd1;
   localparam logic [STYLE_W-1:0] STYLE_DASHDOT = 2'd2;

   localparam int PHASE_COUNT = 6;
   localparam int DASH_LEN    = 3;
   localparam int DOT_PHASE   = 4;

   typedef logic [COORD_BITS-1:0]     coord_type;
   typedef logic [STYLE_W-1:0]        style_type;
   typedef logic signed [INC_W-1:0]   inc_type;
   typedef logic signed [ACC_W-1:0]   acc_type;

   typedef struct packed {
      logic load;
      logic set_x_inc;
      logic set_y_inc;
      logic advance;
   } walk_ctl_type;

endpackage

@@ rtl/dslr_if.sv @@
`timescale 1ns / 1ps
interface dslr_req_if;
   import dslr_pkg::*;

   logic      valid;
   logic      ready;
   logic      op;
   coord_type x_start;
   coord_type y_start;
   coord_type x_end;
   coord_type y_end;
   style_type style;

   modport source (output valid, op, x_start, y_start, x_end, y_end, style, input ready);
   modport sink   (input valid, op, x_start, y_start, x_end, y_end, style, output ready);
endinterface

interface dslr_rsp_if;
   import dslr_pkg::*;

   logic      valid;
   logic      ready;
   coord_type px;
   coord_type py;
   logic      visible;
   logic      last;

   modport source (output valid, px, py, visible, last, input ready);
   modport sink   (input valid, px, py, visible, last, output ready);
endinterface

@@ rtl/dslr_div.sv @@
`timescale 1ns / 1ps
module dslr_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dslr_pkg::DVD_W-1:0]     dividend,
   input  logic [dslr_pkg::COORD_BITS-1:0] divisor,
   output logic                           done,
   output logic [dslr_pkg::QUO_W-1:0]     quotient
);
   import dslr_pkg::*;

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]      quo_ff, quo_in;
   logic [COORD_BITS-1:0] dsr_ff, dsr_in;

   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS:0]   diff;
   logic                  fits;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (run_ff) begin
         rem_in = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[QUO_W-1:0];

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff) else $error("divider started while running");
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> run_ff && cnt_ff == '0) else $error("divider did not begin");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("divider done while still running");
endmodule

@@ rtl/dslr_walk.sv @@
`timescale 1ns / 1ps
module dslr_walk (
   input  logic                   clock,
   input  logic                   reset,
   input  dslr_pkg::walk_ctl_type ctl,
   input  dslr_pkg::coord_type    x_start,
   input  dslr_pkg::coord_type    y_start,
   input  dslr_pkg::coord_type    total,
   input  dslr_pkg::style_type    style,
   input  dslr_pkg::inc_type      inc,
   output logic                   line_busy,
   output logic                   out_free,
   dslr_rsp_if.source             rsp
);
   import dslr_pkg::*;

   acc_type             x_acc_ff, x_acc_in;
   acc_type             y_acc_ff, y_acc_in;
   inc_type             x_inc_ff, x_inc_in;
   inc_type             y_inc_ff, y_inc_in;
   coord_type           idx_ff, idx_in;
   coord_type           total_ff, total_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   style_type           style_ff, style_in;
   logic                busy_ff, busy_in;
   logic                valid_ff, valid_in;
   coord_type           px_ff, px_in;
   coord_type           py_ff, py_in;
   logic                vis_ff, vis_in;
   logic                last_ff, last_in;

   logic                fin;
   logic                vis;

   function automatic coord_type round_coord(input acc_type acc);
      logic signed [ACC_W:0] sum;
      coord_type             res;
      sum = $signed({acc[ACC_W-1], acc})
          + $signed({{(ACC_W - FRAC_BITS + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}});
      if (sum[ACC_W])
         res = '0;
      else if (|sum[ACC_W-1:FRAC_BITS+COORD_BITS])
         res = '1;
      else
         res = sum[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
      return res;
   endfunction

   assign fin = idx_ff == total_ff;

   always_comb begin
      unique case (style_ff)
         STYLE_DOTTED:  vis = !idx_ff[0];
         STYLE_DASHDOT: vis = (phase_ff < PHASE_W'(DASH_LEN)) || (phase_ff == PHASE_W'(DOT_PHASE));
         default:       vis = 1'b0;
      endcase
   end

   always_comb begin
      x_acc_in = x_acc_ff;
      y_acc_in = y_acc_ff;
      x_inc_in = x_inc_ff;
      y_inc_in = y_inc_ff;
      idx_in   = idx_ff;
      total_in = total_ff;
      phase_in = phase_ff;
      style_in = style_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      vis_in   = vis_ff;
      last_in  = last_ff;

      if (valid_ff && rsp.ready)
         valid_in = 1'b0;

      if (ctl.load) begin
         x_acc_in = ACC_W'({x_start, {FRAC_BITS{1'b0}}});
         y_acc_in = ACC_W'({y_start, {FRAC_BITS{1'b0}}});
         x_inc_in = '0;
         y_inc_in = '0;
         idx_in   = '0;
         total_in = total;
         phase_in = '0;
         style_in = style;
         busy_in  = 1'b1;
      end
      if (ctl.set_x_inc)
         x_inc_in = inc;
      if (ctl.set_y_inc)
         y_inc_in = inc;
      if (ctl.advance) begin
         valid_in = 1'b1;
         px_in    = round_coord(x_acc_ff);
         py_in    = round_coord(y_acc_ff);
         vis_in   = vis;
         last_in  = fin;
         x_acc_in = x_acc_ff + ACC_W'(x_inc_ff);
         y_acc_in = y_acc_ff + ACC_W'(y_inc_ff);
         idx_in   = idx_ff + COORD_BITS'(1);
         phase_in = (phase_ff == PHASE_W'(PHASE_COUNT - 1)) ? '0 : phase_ff + PHASE_W'(1);
         if (fin)
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_acc_ff <= '0;
         y_acc_ff <= '0;
         x_inc_ff <= '0;
         y_inc_ff <= '0;
         idx_ff   <= '0;
         total_ff <= '0;
         phase_ff <= '0;
         style_ff <= '0;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         x_acc_ff <= x_acc_in;
         y_acc_ff <= y_acc_in;
         x_inc_ff <= x_inc_in;
         y_inc_ff <= y_inc_in;
         idx_ff   <= idx_in;
         total_ff <= total_in;
         phase_ff <= phase_in;
         style_ff <= style_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      px_ff   <= px_in;
      py_ff   <= py_in;
      vis_ff  <= vis_in;
      last_ff <= last_in;
   end

   assign rsp.valid   = valid_ff;
   assign rsp.px      = px_ff;
   assign rsp.py      = py_ff;
   assign rsp.visible = vis_ff;
   assign rsp.last    = last_ff;
   assign line_busy   = busy_ff;
   assign out_free    = !valid_ff || rsp.ready;

   a_adv_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.advance |-> busy_ff && out_free) else $error("point taken with no line or no room");
   a_load: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> busy_ff && idx_ff == '0 && phase_ff == '0) else $error("line load failed");
   a_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff < PHASE_W'(PHASE_COUNT)) else $error("pattern phase out of range");
   a_fin: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && fin && !ctl.load |=> !busy_ff && valid_ff && last_ff)
      else $error("final point did not end the line");
endmodule

@@ rtl/dda_styled_line_rasterizer_top.sv @@
`timescale 1ns / 1ps
// styled dda line rasterizer
// req channel: op 0 starts a line from (x_start, y_start) to (x_end, y_end) with
// a style (1 dotted, 2 dash-dot, others unlit); op 1 asks for the next point.
// rsp channel: one transaction per step request while a line is active, carrying
// the rounded point, a visible flag and a last flag on the final point.
// a start gives no response; a step with no active line is taken and dropped.
// a start of a nonzero line runs the shared restoring divider twice, once per
// axis, at one quotient bit per cycle: req is not ready until both divisions
// are done (a zero-length line needs no division).
// step requests go one per cycle while rsp keeps taking points; each point appears
// on rsp the cycle after its request is taken, from an output register.
// when rsp stalls the single output register holds the point and req stays not
// ready until the waiting point is taken in the same or an earlier cycle.
// reset (synchronous, active high) leaves no line active and rsp empty.
module dda_styled_line_rasterizer_top (
   input logic        clock,
   input logic        reset,
   dslr_req_if.sink   req_if,
   dslr_rsp_if.source rsp_if
);
   import dslr_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_DIV_X = 2'd1;
   localparam logic [1:0] S_DIV_Y = 2'd2;

   logic [1:0]             state_ff, state_in;
   coord_type              mag_y_ff, mag_y_in;
   coord_type              steps_ff, steps_in;
   logic                   neg_x_ff, neg_x_in;
   logic                   neg_y_ff, neg_y_in;

   logic                   accept;
   logic                   line_busy;
   logic                   out_free;
   walk_ctl_type           ctl;
   logic signed [COORD_BITS:0] dx, dy;
   coord_type              ax, ay, steps;
   logic                   div_start;
   logic                   div_done;
   logic [DVD_W-1:0]       dividend;
   coord_type              divisor;
   logic [QUO_W-1:0]       quotient;
   inc_type                mag_inc;
   inc_type                inc;

   assign req_if.ready = (state_ff == S_IDLE) && out_free;
   assign accept       = req_if.valid && req_if.ready;

   assign dx    = $signed({1'b0, req_if.x_end}) - $signed({1'b0, req_if.x_start});
   assign dy    = $signed({1'b0, req_if.y_end}) - $signed({1'b0, req_if.y_start});
   assign ax    = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
   assign ay    = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
   assign steps = (ax > ay) ? ax : ay;

   assign ctl.load      = accept && (req_if.op == OP_START);
   assign ctl.advance   = accept && (req_if.op == OP_STEP) && line_busy;
   assign ctl.set_x_inc = (state_ff == S_DIV_X) && div_done;
   assign ctl.set_y_inc = (state_ff == S_DIV_Y) && div_done;

   // x axis divides straight from the request, y axis from the latched magnitude
   assign div_start = (ctl.load && steps != '0) || ctl.set_x_inc;
   assign dividend  = (state_ff == S_IDLE) ? {ax, {FRAC_BITS{1'b0}}}
                                           : {mag_y_ff, {FRAC_BITS{1'b0}}};
   assign divisor   = (state_ff == S_IDLE) ? steps : steps_ff;

   assign mag_inc = INC_W'(quotient);
   assign inc     = ((state_ff == S_DIV_X) ? neg_x_ff : neg_y_ff) ? -mag_inc : mag_inc;

   always_comb begin
      state_in = state_ff;
      mag_y_in = mag_y_ff;
      steps_in = steps_ff;
      neg_x_in = neg_x_ff;
      neg_y_in = neg_y_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.load) begin
               mag_y_in = ay;
               steps_in = steps;
               neg_x_in = dx[COORD_BITS];
               neg_y_in = dy[COORD_BITS];
               if (steps != '0)
                  state_in = S_DIV_X;
            end
         end
         S_DIV_X: if (div_done) state_in = S_DIV_Y;
         S_DIV_Y: if (div_done) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_y_ff <= mag_y_in;
      steps_ff <= steps_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
   end

   dslr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   dslr_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .x_start   (req_if.x_start),
      .y_start   (req_if.y_start),
      .total     (steps),
      .style     (req_if.style),
      .inc       (inc),
      .line_busy (line_busy),
      .out_free  (out_free),
      .rsp       (rsp_if)
   );

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_if.ready) else $error("request taken during division");
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV_X || state_ff == S_DIV_Y)
      else $error("divider finished with no division pending");
   a_zero_line: assert property (@(posedge clock) disable iff (reset)
      ctl.load && steps == '0 |=> state_ff == S_IDLE) else $error("zero-length line divided");
endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import dslr_pkg::*;

   localparam int     MAX_SHOWN    = 10;
   localparam longint CYCLE_LIMIT  = 400000;
   localparam int     DRAIN_CYCLES = 64;
   localparam int     RANDOM_ITEMS = 1600;
   localparam int     COORD_MAX    = (1 << COORD_BITS) - 1;

   localparam style_type STYLE_NONE  = 2'd0;
   localparam style_type STYLE_OTHER = 2'd3;

   typedef struct packed {
      logic      op;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
      style_type style;
   } line_cmd_type;

   typedef struct packed {
      coord_type px;
      coord_type py;
      logic      visible;
      logic      last;
   } point_type;

   class point_scoreboard;
      acc_type            x_pos;
      acc_type            y_pos;
      inc_type            x_inc;
      inc_type            y_inc;
      coord_type          step_idx;
      coord_type          step_last;
      logic [PHASE_W-1:0] phase;
      style_type          line_style;
      logic               active;
      point_type          pending_points[$];
      int                 mismatches;

      function new();
         x_pos      = '0;
         y_pos      = '0;
         x_inc      = '0;
         y_inc      = '0;
         step_idx   = '0;
         step_last  = '0;
         phase      = '0;
         line_style = '0;
         active     = 1'b0;
         mismatches = 0;
      endfunction

      // per-step increment, truncated toward zero in magnitude
      function inc_type slope(coord_type from_c, coord_type to_c, coord_type steps);
         logic [DVD_W-1:0] mag;
         logic [DVD_W-1:0] quo;
         if (steps == 0) return '0;
         mag = (to_c >= from_c) ? DVD_W'(to_c - from_c) : DVD_W'(from_c - to_c);
         quo = (mag << FRAC_BITS) / DVD_W'(steps);
         return (to_c < from_c) ? -inc_type'(quo) : inc_type'(quo);
      endfunction

      // round half up, then clamp to the screen
      function coord_type snap(acc_type pos);
         longint sum;
         sum = longint'(pos) + (longint'(1) << (FRAC_BITS - 1));
         if (sum < 0) return '0;
         sum = sum >>> FRAC_BITS;
         if (sum > COORD_MAX) return '1;
         return coord_type'(sum);
      endfunction

      function void note_input(line_cmd_type cmd);
         coord_type adx;
         coord_type ady;
         coord_type steps;
         point_type pt;
         if (cmd.op == OP_START) begin
            adx = (cmd.x_end >= cmd.x_start) ? cmd.x_end - cmd.x_start
                                             : cmd.x_start - cmd.x_end;
            ady = (cmd.y_end >= cmd.y_start) ? cmd.y_end - cmd.y_start
                                             : cmd.y_start - cmd.y_end;
            steps      = (adx > ady) ? adx : ady;
            x_inc      = slope(cmd.x_start, cmd.x_end, steps);
            y_inc      = slope(cmd.y_start, cmd.y_end, steps);
            x_pos      = acc_type'(cmd.x_start) << FRAC_BITS;
            y_pos      = acc_type'(cmd.y_start) << FRAC_BITS;
            step_last  = steps;
            step_idx   = '0;
            phase      = '0;
            line_style = cmd.style;
            active     = 1'b1;
         end else if (active) begin
            pt.px   = snap(x_pos);
            pt.py   = snap(y_pos);
            pt.last = (step_idx == step_last);
            if (line_style == STYLE_DOTTED)
               pt.visible = ~step_idx[0];
            else if (line_style == STYLE_DASHDOT)
               pt.visible = (phase < DASH_LEN) || (phase == DOT_PHASE);
            else
               pt.visible = 1'b0;
            pending_points.push_back(pt);
            x_pos    = x_pos + x_inc;
            y_pos    = y_pos + y_inc;
            step_idx = step_idx + 1'b1;
            phase    = (phase == PHASE_COUNT - 1) ? '0 : phase + 1'b1;
            if (pt.last) active = 1'b0;
         end
      endfunction

      function void flag(string what, point_type want, point_type got);
         mismatches++;
         if (mismatches <= MAX_SHOWN)
            $display("%0t: %s: expected px=%0d py=%0d vis=%0b last=%0b,",
                     $time, what, want.px, want.py, want.visible, want.last,
                     " got px=%0d py=%0d vis=%0b last=%0b",
                     got.px, got.py, got.visible, got.last);
      endfunction

      function void check_result(point_type got);
         point_type want;
         if (pending_points.size() == 0) begin
            flag("point with none pending", '0, got);
         end else begin
            want = pending_points.pop_front();
            if (got.px !== want.px || got.py !== want.py ||
                got.visible !== want.visible || got.last !== want.last)
               flag("point mismatch", want, got);
         end
      endfunction

      function int outstanding();
         return pending_points.size();
      endfunction

      function int close_out();
         while (pending_points.size() > 0)
            flag("point never delivered", pending_points.pop_front(), '0);
         return mismatches;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   dslr_req_if req_if ();
   dslr_rsp_if rsp_if ();

   dda_styled_line_rasterizer_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #5 clock = ~clock;

   point_scoreboard board;
   line_cmd_type    seen_cmd;
   point_type       seen_pt;
   int              burst_left;
   int              items_sent;
   int              rsp_phase;
   longint          cycle_count;

   // observe both channels at the edge where transactions complete
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen_cmd = '{req_if.op, req_if.x_start, req_if.y_start,
                         req_if.x_end, req_if.y_end, req_if.style};
            board.note_input(seen_cmd);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen_pt = '{rsp_if.px, rsp_if.py, rsp_if.visible, rsp_if.last};
            board.check_result(seen_pt);
         end
      end
   end

   // receiver back-pressure, switching among four patterns on a free-running counter
   always @(posedge clock) begin
      rsp_phase <= rsp_phase + 1;
      case (rsp_phase[9:8])
         2'd0: begin
            rsp_if.ready <= 1'b1;
         end
         2'd1: begin
            rsp_if.ready <= 1'($urandom_range(0, 1));
         end
         2'd2: begin
            rsp_if.ready <= (rsp_phase[2:0] == 3'd0);
         end
         default: begin
            rsp_if.ready <= (rsp_phase[4:0] >= 5'd12);
         end
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic line_cmd_type random_cmd(logic op);
      line_cmd_type cmd;
      cmd.op      = op;
      cmd.x_start = coord_type'($urandom);
      cmd.y_start = coord_type'($urandom);
      cmd.x_end   = coord_type'($urandom);
      cmd.y_end   = coord_type'($urandom);
      cmd.style   = style_type'($urandom);
      return cmd;
   endfunction

   function automatic coord_type near(coord_type base, int span);
      int v;
      v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return coord_type'(v);
   endfunction

   task automatic send(line_cmd_type cmd);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      items_sent++;
      req_if.valid   <= 1'b1;
      req_if.op      <= cmd.op;
      req_if.x_start <= cmd.x_start;
      req_if.y_start <= cmd.y_start;
      req_if.x_end   <= cmd.x_end;
      req_if.y_end   <= cmd.y_end;
      req_if.style   <= cmd.style;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // start a line, then ask for n_steps points
   task automatic draw(coord_type xs, coord_type ys, coord_type xe, coord_type ye,
                       style_type sty, int n_steps);
      line_cmd_type cmd;
      cmd = '{OP_START, xs, ys, xe, ye, sty};
      send(cmd);
      repeat (n_steps) send(random_cmd(OP_STEP));
   endtask

   initial begin
      int        target;
      int        kind;
      int        span;
      int        dx;
      int        dy;
      int        n_points;
      coord_type xs;
      coord_type ys;
      coord_type xe;
      coord_type ye;
      style_type sty;

      board          = new();
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.op      = OP_START;
      req_if.x_start = '0;
      req_if.y_start = '0;
      req_if.x_end   = '0;
      req_if.y_end   = '0;
      req_if.style   = '0;
      burst_left     = 0;
      items_sent     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // step with no line active, all payload bits set
      send('{OP_STEP, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 2'h3});
      // zero-length line, then a step after it has finished
      draw(10'd1023, 10'd1023, 10'd1023, 10'd1023, STYLE_DOTTED, 1);
      send('{OP_STEP, 10'h000, 10'h000, 10'h000, 10'h000, 2'h0});
      // full diagonal cut short by a restart
      draw(10'd0, 10'd0, 10'd1023, 10'd1023, STYLE_DASHDOT, 3);
      draw(10'd1023, 10'd0, 10'd1019, 10'd3, STYLE_OTHER, 5);
      draw(10'd0, 10'd1023, 10'd5, 10'd1021, STYLE_NONE, 6);
      // half-unit y increment exercises round half up
      draw(10'd10, 10'd10, 10'd12, 10'd11, STYLE_DASHDOT, 3);

      target = items_sent + RANDOM_ITEMS;

      // one full-width or full-height line so the step counter reaches its top
      ys = coord_type'($urandom);
      ye = coord_type'($urandom);
      if ($urandom_range(0, 1))
         draw(10'd0, ys, 10'd1023, ye, style_type'($urandom_range(1, 2)), 1024);
      else
         draw(ys, 10'd1023, ye, 10'd0, style_type'($urandom_range(1, 2)), 1024);

      while (items_sent < target) begin
         kind = $urandom_range(0, 99);
         span = ($urandom_range(0, 9) == 0) ? 60 : 12;
         xs   = coord_type'($urandom);
         ys   = coord_type'($urandom);
         xe   = near(xs, span);
         ye   = near(ys, span);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: sty = STYLE_DOTTED;
            4, 5, 6, 7: sty = STYLE_DASHDOT;
            8:          sty = STYLE_NONE;
            default:    sty = STYLE_OTHER;
         endcase
         dx       = int'(xe) - int'(xs);
         dy       = int'(ye) - int'(ys);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         n_points = ((dx > dy) ? dx : dy) + 1;
         if (kind < 80) begin
            draw(xs, ys, xe, ye, sty, n_points);
            if ($urandom_range(0, 9) == 0) send(random_cmd(OP_STEP));
         end else if (kind < 90) begin
            // abandoned midway, the next start replaces it
            draw(xs, ys, xe, ye, sty, $urandom_range(0, n_points - 1));
         end else begin
            draw(coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                 coord_type'($urandom), style_type'($urandom), $urandom_range(0, 3));
         end
      end

      req_if.valid <= 1'b0;
      while (board.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.close_out() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
